[hdl/ihdc_pkg.sv]
// shared types and constants for the image header dimension check
// no dependencies; imported by ihdc_parse and image_header_dimension_check
package ihdc_pkg;

    // format codes as delivered on format_kind
    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_PNG     = 2'd1,
        FMT_JPEG    = 2'd2
    } format_t;

    // configuration register indexes
    localparam logic CFG_MAX_SIDE   = 1'b0;
    localparam logic CFG_MAX_PIXELS = 1'b1;

    localparam logic [15:0] MAX_SIDE_RESET   = 16'd16384;
    localparam logic [28:0] MAX_PIXELS_RESET = 29'd64000000;

    localparam logic [31:0] PNG_SIGNATURE = 32'h8950_4E47;
    localparam logic [15:0] JPEG_SOI      = 16'hFFD8;
    localparam logic [7:0]  MARK_PREFIX   = 8'hFF;
    localparam logic [7:0]  MARK_SOF_LO   = 8'hC0;
    localparam logic [7:0]  MARK_SOF_HI   = 8'hCF;
    localparam logic [7:0]  MARK_DHT      = 8'hC4;
    localparam logic [7:0]  MARK_JPG      = 8'hC8;
    localparam logic [7:0]  MARK_DAC      = 8'hCC;

    // marker segment walk, one-hot
    typedef enum logic [9:0] {
        PH_SEEK   = 10'b00_0000_0001,
        PH_MARK   = 10'b00_0000_0010,
        PH_LEN_HI = 10'b00_0000_0100,
        PH_LEN_LO = 10'b00_0000_1000,
        PH_PAD    = 10'b00_0001_0000,
        PH_DIM0   = 10'b00_0010_0000,
        PH_DIM1   = 10'b00_0100_0000,
        PH_DIM2   = 10'b00_1000_0000,
        PH_DIM3   = 10'b01_0000_0000,
        PH_FOUND  = 10'b10_0000_0000
    } walk_phase_t;

    // header findings for one blob, before the limit check
    typedef struct packed {
        format_t     kind;
        logic [31:0] width;
        logic [31:0] height;
    } verdict_t;

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI) &&
               (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

endpackage

[hdl/ihdc_parse.sv]
// per-byte header parser: signature, png ihdr words and jpeg marker walk
// depends on ihdc_pkg; verdict is combinational for the beat on the port
module ihdc_parse #(
    parameter int POS_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat_accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output ihdc_pkg::verdict_t verdict
);
    import ihdc_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [31:0]         sig_reg, sig_next;
    logic [31:0]         png_w_reg, png_w_next;
    logic [31:0]         png_h_reg, png_h_next;
    walk_phase_t         phase_reg, phase_next;
    logic [POS_BITS-1:0] cand_reg, cand_next;
    logic [7:0]          marker_reg, marker_next;
    logic [7:0]          len_hi_reg, len_hi_next;
    logic [31:0]         dims_reg, dims_next;
    logic [POS_BITS-1:0] commit_reg, commit_next;
    logic                stopped_reg, stopped_next;

    logic [15:0]         seg_len;
    logic [POS_BITS:0]   seg_end;

    assign seg_len = {len_hi_reg, data_byte};
    assign seg_end = {1'b0, cand_reg} + (POS_BITS+1)'(seg_len) + (POS_BITS+1)'(2);

    always_comb
    begin
        pos_next     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        sig_next     = sig_reg;
        png_w_next   = png_w_reg;
        png_h_next   = png_h_reg;
        phase_next   = phase_reg;
        cand_next    = cand_reg;
        marker_next  = marker_reg;
        len_hi_next  = len_hi_reg;
        dims_next    = dims_reg;
        commit_next  = commit_reg;
        stopped_next = stopped_reg;

        if (pos_reg < POS_BITS'(4))
        begin
            sig_next = {sig_reg[23:0], data_byte};
        end
        else if (pos_reg >= POS_BITS'(16) && pos_reg < POS_BITS'(20))
        begin
            png_w_next = {png_w_reg[23:0], data_byte};
        end
        else if (pos_reg >= POS_BITS'(20) && pos_reg < POS_BITS'(24))
        begin
            png_h_next = {png_h_reg[23:0], data_byte};
        end

        // walk freezes once stopped or at the saturated position
        if (!stopped_reg && pos_reg != POS_MAX)
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    if (pos_reg == cand_reg)
                    begin
                        if (data_byte == MARK_PREFIX)
                            phase_next = PH_MARK;
                        else
                            cand_next = pos_reg + 1'b1;
                    end
                end
                PH_MARK:
                begin
                    marker_next = data_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_hi_next = data_byte;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (is_frame_marker(marker_reg))
                        phase_next = PH_PAD;
                    else if (seg_len < 16'd2)
                        stopped_next = 1'b1;
                    else if (seg_end >= {1'b0, POS_MAX})
                        stopped_next = 1'b1;
                    else
                    begin
                        cand_next  = seg_end[POS_BITS-1:0];
                        phase_next = PH_SEEK;
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_DIM0;
                end
                PH_DIM0:
                begin
                    dims_next  = {dims_reg[23:0], data_byte};
                    phase_next = PH_DIM1;
                end
                PH_DIM1:
                begin
                    dims_next  = {dims_reg[23:0], data_byte};
                    phase_next = PH_DIM2;
                end
                PH_DIM2:
                begin
                    dims_next  = {dims_reg[23:0], data_byte};
                    phase_next = PH_DIM3;
                end
                PH_DIM3:
                begin
                    dims_next    = {dims_reg[23:0], data_byte};
                    commit_next  = pos_reg + 1'b1;
                    phase_next   = PH_FOUND;
                    stopped_next = 1'b1;
                end
                default:
                begin
                    stopped_next = 1'b1;
                end
            endcase
        end
    end

    // findings as of this beat, used only when it carries last_byte
    always_comb
    begin
        verdict.kind   = FMT_UNKNOWN;
        verdict.width  = '0;
        verdict.height = '0;
        if (pos_reg >= POS_BITS'(23) && sig_next == PNG_SIGNATURE)
        begin
            verdict.kind   = FMT_PNG;
            verdict.width  = png_w_next;
            verdict.height = png_h_next;
        end
        else if (pos_reg >= POS_BITS'(3) && sig_next[31:16] == JPEG_SOI)
        begin
            verdict.kind = FMT_JPEG;
            if (phase_next == PH_FOUND && pos_reg >= commit_next)
            begin
                verdict.width  = {16'd0, dims_next[15:0]};
                verdict.height = {16'd0, dims_next[31:16]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sig_reg     <= '0;
            png_w_reg   <= '0;
            png_h_reg   <= '0;
            phase_reg   <= PH_SEEK;
            cand_reg    <= POS_BITS'(2);
            marker_reg  <= '0;
            len_hi_reg  <= '0;
            dims_reg    <= '0;
            commit_reg  <= '0;
            stopped_reg <= 1'b0;
        end
        else if (beat_accept)
        begin
            if (last_byte)
            begin
                // blob done, start over for the next one
                pos_reg     <= '0;
                sig_reg     <= '0;
                png_w_reg   <= '0;
                png_h_reg   <= '0;
                phase_reg   <= PH_SEEK;
                cand_reg    <= POS_BITS'(2);
                marker_reg  <= '0;
                len_hi_reg  <= '0;
                dims_reg    <= '0;
                commit_reg  <= '0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                sig_reg     <= sig_next;
                png_w_reg   <= png_w_next;
                png_h_reg   <= png_h_next;
                phase_reg   <= phase_next;
                cand_reg    <= cand_next;
                marker_reg  <= marker_next;
                len_hi_reg  <= len_hi_next;
                dims_reg    <= dims_next;
                commit_reg  <= commit_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

[hdl/image_header_dimension_check.sv]
// top level of the image header dimension check: limits, verdict pipeline
// depends on ihdc_pkg and ihdc_parse
//
// usage
//   input channel: one blob byte per beat (data_byte, last_byte) under
//   in_valid / in_stall. a beat is taken at a clock edge with in_valid high
//   and in_stall low. bytes without last_byte produce nothing.
//   output channel: one verdict per blob (safe, format_kind, width_found,
//   height_found) under out_valid / out_stall, same acceptance rule.
//   config: cfg_write with cfg_index 0 sets max_side, 1 sets max_pixels;
//   write only while no blob is in flight.
// timing
//   one byte per cycle while in_stall is low. the verdict for a last beat
//   shows on out_valid once the parser findings have loaded the findings
//   register at the accepting edge and the limit check (one 16x16 multiply
//   and compare) has loaded the output register as soon as it is free.
// reset
//   rst_n clears the parser, empties the pipeline and restores the limits
//   to 16384 and 64000000.
// stall
//   a stalled verdict holds; one more verdict can wait in the findings
//   register, after which in_stall rises until the output drains.
module image_header_dimension_check #(
    parameter int POS_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // verdict channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        safe,
    output logic [1:0]  format_kind,
    output logic [31:0] width_found,
    output logic [31:0] height_found,
    // limit registers
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [28:0] cfg_data
);
    import ihdc_pkg::*;

    logic [15:0] max_side_reg;
    logic [28:0] max_pixels_reg;

    logic        beat_accept;
    logic        advance;
    verdict_t    verdict;

    // findings stage
    logic        find_valid_reg;
    verdict_t    find_reg;

    // output stage
    logic        out_valid_reg;
    logic        safe_reg;
    logic [1:0]  kind_reg;
    logic [31:0] width_reg;
    logic [31:0] height_reg;

    // limit check
    logic        dims_nonzero;
    logic        sides_ok;
    logic [31:0] area;
    logic        area_ok;
    logic        safe_next;

    // output register frees up when empty or being taken this cycle
    assign advance     = !out_valid_reg || !out_stall;
    assign in_stall    = find_valid_reg && !advance;
    assign beat_accept = in_valid && !in_stall;

    ihdc_parse #(
        .POS_BITS(POS_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_accept(beat_accept),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .verdict    (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_side_reg   <= MAX_SIDE_RESET;
            max_pixels_reg <= MAX_PIXELS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_SIDE:   max_side_reg   <= cfg_data[15:0];
                CFG_MAX_PIXELS: max_pixels_reg <= cfg_data;
            endcase
        end
    end

    // only the last beat of a blob enters the findings stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_valid_reg <= 1'b0;
        end
        else if (beat_accept && last_byte)
        begin
            find_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            find_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_accept && last_byte)
        begin
            find_reg <= verdict;
        end
    end

    // once both sides are within max_side they fit in 16 bits,
    // so a 16x16 product settles the area limit
    assign dims_nonzero = (find_reg.width != 32'd0) && (find_reg.height != 32'd0);
    assign sides_ok     = (find_reg.width <= {16'd0, max_side_reg}) &&
                          (find_reg.height <= {16'd0, max_side_reg});
    assign area         = 32'(find_reg.width[15:0]) * 32'(find_reg.height[15:0]);
    assign area_ok      = area <= {3'd0, max_pixels_reg};
    assign safe_next    = (find_reg.kind == FMT_UNKNOWN) ||
                          (dims_nonzero && sides_ok && area_ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= find_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && find_valid_reg)
        begin
            safe_reg   <= safe_next;
            kind_reg   <= find_reg.kind;
            width_reg  <= find_reg.width;
            height_reg <= find_reg.height;
        end
    end

    assign out_valid    = out_valid_reg;
    assign safe         = safe_reg;
    assign format_kind  = kind_reg;
    assign width_found  = width_reg;
    assign height_found = height_reg;

endmodule
